/* src/pdll_pkg.sv */
// Package for the pooled doubly linked list core.
// Holds widths, command/status codes, datapath op codes and the
// controller/datapath command and status structs. No dependencies.
package pdll_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int POS_W      = 10;
  localparam int DATA_W     = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } st_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_STATUS,
    OP_WALK_ADV,
    OP_APP1,
    OP_APP2,
    OP_INS1,
    OP_INS2,
    OP_INS3,
    OP_ERS_RD,
    OP_ERS_UPD,
    OP_ERS_FIN,
    OP_SCAN_END,
    OP_SCAN_CHK
  } dp_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_WALK_ADV,
    S_APP1,
    S_APP2,
    S_INS1,
    S_INS2,
    S_INS3,
    S_ERS_RD,
    S_ERS_UPD,
    S_ERS_FIN,
    S_SCAN,
    S_SCAN_CHK,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    dp_op_t op;
    st_t    status;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic clr_last;
    logic full;
    logic pos_gt;
    logic pos_eq;
    logic pos_ge;
    logic cnt_zero;
    logic walk_done;
    logic scan_end;
    logic scan_free;
  } sts_t;

endpackage

/* src/pdll_intf.sv */
// Valid/ready channel interfaces for the list core: command in, result out.
// Depends on pdll_pkg for field widths.
interface pdll_in_if;
  import pdll_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] data_word;
  modport source (output valid, command, position, data_word, input ready);
  modport sink   (input valid, command, position, data_word, output ready);
endinterface

interface pdll_out_if;
  import pdll_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot;
  logic              slot_valid;
  logic [DATA_W-1:0] next_data;
  logic [CNT_W-1:0]  length;
  modport source (output valid, status, slot, slot_valid, next_data, length, input ready);
  modport sink   (input valid, status, slot, slot_valid, next_data, length, output ready);
endinterface

/* src/pdll_dp.sv */
// Datapath of the list core: link/payload/in-use memories, list registers,
// walk and free-slot scan cursors, result registers. Uses pdll_pkg.
module pdll_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pdll_pkg::ctl_t               ctl_i,
  output pdll_pkg::sts_t               sts_o,
  input  logic [1:0]                   cmd_i,
  input  logic [pdll_pkg::POS_W-1:0]   pos_i,
  input  logic [pdll_pkg::DATA_W-1:0]  data_i,
  output logic [1:0]                   status_o,
  output logic [pdll_pkg::SLOT_W-1:0]  slot_o,
  output logic                         slot_valid_o,
  output logic [pdll_pkg::DATA_W-1:0]  next_data_o,
  output logic [pdll_pkg::CNT_W-1:0]   length_o
);
  import pdll_pkg::*;

  // memories
  logic [SLOT_W-1:0] prev_mem [POOL_DEPTH];
  logic [SLOT_W-1:0] next_mem [POOL_DEPTH];
  logic [DATA_W-1:0] pay_mem  [POOL_DEPTH];
  logic              use_mem  [POOL_DEPTH];

  logic [SLOT_W-1:0] rd_prev_r, rd_next_r;
  logic [DATA_W-1:0] rd_pay_r;
  logic              rd_use_r;

  // list state
  logic [SLOT_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0]  count_r, lf_r, sc_r;

  // per-transaction registers
  cmd_t              cmd_r;
  logic [POS_W-1:0]  pos_r, idx_r;
  logic [DATA_W-1:0] data_r;
  logic [SLOT_W-1:0] walk_r, n_r;
  logic              et_head_r, et_tail_r;
  st_t               res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_valid_r;
  logic [DATA_W-1:0] res_ndata_r;

  logic [SLOT_W-1:0] s_slot;
  logic              prev_we, next_we, pay_we, use_we, use_wd;
  logic [SLOT_W-1:0] prev_wa, prev_wd, next_wa, next_wd, pay_wa, use_wa;
  logic [CNT_W-1:0]  pos_ext;

  assign s_slot  = lf_r[SLOT_W-1:0];
  assign pos_ext = CNT_W'(pos_r);

  // status to controller
  always_comb begin
    sts_o.cmd       = cmd_r;
    sts_o.clr_last  = (sc_r == CNT_W'(POOL_DEPTH - 1));
    sts_o.full      = (lf_r == CNT_W'(POOL_DEPTH));
    sts_o.pos_gt    = (pos_ext > count_r);
    sts_o.pos_eq    = (pos_ext == count_r);
    sts_o.pos_ge    = (pos_ext >= count_r);
    sts_o.cnt_zero  = (count_r == '0);
    sts_o.walk_done = (idx_r == pos_r);
    sts_o.scan_end  = (sc_r == CNT_W'(POOL_DEPTH));
    sts_o.scan_free = !rd_use_r;
  end

  // memory write controls
  always_comb begin
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    pay_we  = 1'b0; pay_wa  = '0;
    use_we  = 1'b0; use_wa  = '0; use_wd = 1'b0;
    case (ctl_i.op)
      OP_CLEAR: begin
        use_we = 1'b1; use_wa = sc_r[SLOT_W-1:0];
      end
      OP_APP1: begin
        pay_we = 1'b1; pay_wa = s_slot;
        use_we = 1'b1; use_wa = s_slot; use_wd = 1'b1;
        if (count_r != '0) begin
          next_we = 1'b1; next_wa = tail_r; next_wd = s_slot;
          prev_we = 1'b1; prev_wa = s_slot; prev_wd = tail_r;
        end
      end
      OP_APP2: begin
        next_we = 1'b1; next_wa = s_slot; next_wd = s_slot;
      end
      OP_INS1: begin
        pay_we  = 1'b1; pay_wa = s_slot;
        use_we  = 1'b1; use_wa = s_slot; use_wd = 1'b1;
        next_we = 1'b1; next_wa = s_slot; next_wd = walk_r;
      end
      OP_INS2: begin
        prev_we = 1'b1; prev_wa = s_slot;
        if (walk_r == head_r) begin
          prev_wd = s_slot;
        end else begin
          prev_wd = rd_prev_r;
          next_we = 1'b1; next_wa = rd_prev_r; next_wd = s_slot;
        end
      end
      OP_INS3: begin
        prev_we = 1'b1; prev_wa = walk_r; prev_wd = s_slot;
      end
      OP_ERS_UPD: begin
        if (!et_head_r) begin
          next_we = 1'b1; next_wa = rd_prev_r;
          next_wd = et_tail_r ? rd_prev_r : rd_next_r;
        end
        if (!et_tail_r) begin
          prev_we = 1'b1; prev_wa = rd_next_r;
          prev_wd = et_head_r ? rd_next_r : rd_prev_r;
        end
        use_we = 1'b1; use_wa = walk_r;
      end
      default: ;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (pay_we)  pay_mem[pay_wa]   <= data_r;
    if (use_we)  use_mem[use_wa]   <= use_wd;
    rd_prev_r <= prev_mem[walk_r];
    rd_next_r <= next_mem[walk_r];
    rd_pay_r  <= pay_mem[rd_next_r];
    rd_use_r  <= use_mem[sc_r[SLOT_W-1:0]];
  end

  // list state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      lf_r    <= '0;
      sc_r    <= '0;
    end else begin
      case (ctl_i.op)
        OP_CLEAR: sc_r <= sc_r + 1'b1;
        OP_APP2: begin
          if (count_r == '0) head_r <= s_slot;
          tail_r  <= s_slot;
          count_r <= count_r + 1'b1;
          sc_r    <= lf_r + 1'b1;
        end
        OP_INS2: if (walk_r == head_r) head_r <= s_slot;
        OP_INS3: begin
          count_r <= count_r + 1'b1;
          sc_r    <= lf_r + 1'b1;
        end
        OP_ERS_UPD: begin
          if (et_head_r) head_r <= rd_next_r;
          if (et_tail_r) tail_r <= rd_prev_r;
          count_r <= count_r - 1'b1;
          if (count_r == CNT_W'(1)) begin
            head_r <= '0;
            tail_r <= '0;
          end
          if (CNT_W'(walk_r) < lf_r) lf_r <= CNT_W'(walk_r);
        end
        OP_SCAN_END: lf_r <= CNT_W'(POOL_DEPTH);
        OP_SCAN_CHK: begin
          if (!rd_use_r) lf_r <= sc_r;
          else           sc_r <= sc_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // transaction and result registers
  always_ff @(posedge clk) begin
    case (ctl_i.op)
      OP_LOAD: begin
        cmd_r        <= cmd_t'(cmd_i);
        pos_r        <= pos_i;
        data_r       <= data_i;
        walk_r       <= head_r;
        idx_r        <= '0;
        res_status_r <= ST_OK;
        res_slot_r   <= '0;
        res_valid_r  <= 1'b0;
        res_ndata_r  <= '0;
      end
      OP_STATUS: res_status_r <= ctl_i.status;
      OP_WALK_ADV: begin
        walk_r <= rd_next_r;
        idx_r  <= idx_r + 1'b1;
      end
      OP_APP1, OP_INS1: begin
        res_slot_r  <= s_slot;
        res_valid_r <= 1'b1;
      end
      OP_ERS_RD: begin
        et_head_r <= (walk_r == head_r);
        et_tail_r <= (walk_r == tail_r);
      end
      OP_ERS_UPD: n_r <= rd_next_r;
      OP_ERS_FIN: begin
        if (!et_tail_r) begin
          res_slot_r  <= n_r;
          res_valid_r <= 1'b1;
          res_ndata_r <= rd_pay_r;
        end
      end
      default: ;
    endcase
  end

  assign status_o     = res_status_r;
  assign slot_o       = res_slot_r;
  assign slot_valid_o = res_valid_r;
  assign next_data_o  = res_ndata_r;
  assign length_o     = count_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POOL_DEPTH)) else $error("link count above pool depth");
  a_lf_range: assert property (@(posedge clk) disable iff (!rst_n)
    lf_r <= CNT_W'(POOL_DEPTH)) else $error("free-slot hint out of range");
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == '0 && tail_r == '0)
    else $error("empty list with nonzero head or tail");
  a_erase_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.op == OP_ERS_UPD |-> count_r != '0) else $error("unlink on empty list");

endmodule

/* src/pdll_ctrl.sv */
// Controller state machine of the list core: sequences datapath ops for
// append, insert, erase, the free-slot scan and the reset clear. Uses pdll_pkg.
module pdll_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pdll_pkg::sts_t sts_i,
  output pdll_pkg::ctl_t ctl_o
);
  import pdll_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // next state and datapath ops
  always_comb begin
    state_nxt    = state_r;
    ctl_o.op     = OP_NONE;
    ctl_o.status = ST_OK;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ctl_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl_o.op  = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts_i.cmd) inside
          CMD_APPEND, CMD_INSERT: begin
            if (sts_i.full) begin
              ctl_o.op = OP_STATUS; ctl_o.status = ST_FULL; state_nxt = S_OUT;
            end else if (sts_i.cmd == CMD_INSERT && sts_i.pos_gt) begin
              ctl_o.op = OP_STATUS; ctl_o.status = ST_RANGE; state_nxt = S_OUT;
            end else if (sts_i.cmd == CMD_APPEND || sts_i.pos_eq) begin
              state_nxt = S_APP1;
            end else begin
              state_nxt = S_WALK;
            end
          end
          CMD_ERASE: begin
            if (sts_i.cnt_zero) begin
              ctl_o.op = OP_STATUS; ctl_o.status = ST_EMPTY; state_nxt = S_OUT;
            end else if (sts_i.pos_ge) begin
              ctl_o.op = OP_STATUS; ctl_o.status = ST_RANGE; state_nxt = S_OUT;
            end else begin
              state_nxt = S_WALK;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      // walk from head, one successor per pass through S_WALK and S_WALK_ADV
      S_WALK: begin
        if (sts_i.walk_done)
          state_nxt = (sts_i.cmd == CMD_ERASE) ? S_ERS_RD : S_INS1;
        else
          state_nxt = S_WALK_ADV;
      end
      S_WALK_ADV: begin
        ctl_o.op  = OP_WALK_ADV;
        state_nxt = S_WALK;
      end
      S_APP1: begin ctl_o.op = OP_APP1; state_nxt = S_APP2; end
      S_APP2: begin ctl_o.op = OP_APP2; state_nxt = S_SCAN; end
      S_INS1: begin ctl_o.op = OP_INS1; state_nxt = S_INS2; end
      S_INS2: begin ctl_o.op = OP_INS2; state_nxt = S_INS3; end
      S_INS3: begin ctl_o.op = OP_INS3; state_nxt = S_SCAN; end
      S_ERS_RD:  begin ctl_o.op = OP_ERS_RD;  state_nxt = S_ERS_UPD; end
      S_ERS_UPD: begin ctl_o.op = OP_ERS_UPD; state_nxt = S_ERS_FIN; end
      S_ERS_FIN: begin ctl_o.op = OP_ERS_FIN; state_nxt = S_OUT; end
      // look upward for the next free slot
      S_SCAN: begin
        if (sts_i.scan_end) begin
          ctl_o.op  = OP_SCAN_END;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        ctl_o.op  = OP_SCAN_CHK;
        state_nxt = sts_i.scan_free ? S_OUT : S_SCAN;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* src/pooled_doubly_linked_list_core.sv */
// Pooled doubly linked list core.
//
// Channels: in_ch carries one command per transaction (append, insert
// before position, erase at position) with a data word; out_ch returns
// exactly one result per command: status, slot, slot_valid, next_data
// and the list length after the command. Both are valid/ready; a
// transaction moves when valid and ready are high at a rising clk edge.
// One command is in flight at a time: in_ch.ready is high only while the
// core is idle, and the next command is taken the cycle after the result
// is taken.
// Walking to a position takes one memory read per link passed, in states
// S_WALK and S_WALK_ADV; after an append or insert the free-slot scan
// examines each slot above the new slot, in states S_SCAN and S_SCAN_CHK.
// Reset: rst_n is synchronous, active low. After reset the in-use memory
// is cleared one slot a cycle, all 1024 slots, with in_ch.ready low.
// Stall: a result waits in out_ch with valid high until ready is seen.
// Depends on pdll_pkg, pdll_intf, pdll_ctrl and pdll_dp.
module pooled_doubly_linked_list_core (
  input  logic       clk,
  input  logic       rst_n,
  pdll_in_if.sink    in_ch,
  pdll_out_if.source out_ch
);
  import pdll_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_ready, out_valid;

  pdll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  pdll_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .cmd_i        (in_ch.command),
    .pos_i        (in_ch.position),
    .data_i       (in_ch.data_word),
    .status_o     (out_ch.status),
    .slot_o       (out_ch.slot),
    .slot_valid_o (out_ch.slot_valid),
    .next_data_o  (out_ch.next_data),
    .length_o     (out_ch.length)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

/* dv/pdll_tb_intf.sv */
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces come from src/pdll_intf.sv.
// This file only holds the shared transaction structs used by the bench.
// Depends on pdll_pkg.
package pdll_tb_pkg;
  import pdll_pkg::*;

  typedef struct packed {
    logic [1:0]        command;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data_word;
  } list_cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
    logic [DATA_W-1:0] next_data;
    logic [CNT_W-1:0]  length;
  } list_res_t;
endpackage

/* dv/pooled_doubly_linked_list_core_tb.sv */
`timescale 1ns / 100ps
// Testbench for pooled_doubly_linked_list_core: directed table, then random
// append/insert/erase traffic checked against an in-bench list model.
// Depends on pdll_pkg, pdll_tb_pkg, pdll_intf and the core.
module pooled_doubly_linked_list_core_tb;
  import pdll_pkg::*;
  import pdll_tb_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int         N_RANDOM = 560;

  logic clk;
  logic rst_n;
  pdll_in_if  in_ch();
  pdll_out_if out_ch();

  pooled_doubly_linked_list_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // list shadow
  logic [SLOT_W-1:0] m_prev [POOL_DEPTH];
  logic [SLOT_W-1:0] m_next [POOL_DEPTH];
  logic [DATA_W-1:0] m_data [POOL_DEPTH];
  bit                m_used [POOL_DEPTH];
  logic [SLOT_W-1:0] m_head, m_tail;
  int                m_count;

  list_res_t pending_results[$];
  int        fail_cnt;
  bit        hold_off;

  // directed table; check_row set where the result is typed in
  typedef struct {
    list_cmd_t c;
    bit        check_row;
    list_res_t r;
  } row_t;
  row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("[pooled_doubly_linked_list_core] ERROR");
    $finish;
  end

  function automatic list_res_t mk_res(logic [1:0] st, int sl, bit sv,
                                       logic [DATA_W-1:0] nd, int len);
    list_res_t r;
    r.status = st; r.slot = SLOT_W'(sl); r.slot_valid = sv; r.next_data = nd;
    r.length = CNT_W'(len);
    return r;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < POOL_DEPTH; i++)
      if (!m_used[i]) return i;
    return -1;
  endfunction

  function automatic logic [SLOT_W-1:0] walk_list(int pos);
    logic [SLOT_W-1:0] s;
    s = m_head;
    for (int i = 0; i < pos; i++) s = m_next[s];
    return s;
  endfunction

  // list behavior: one result per command
  function automatic list_res_t apply_list_cmd(list_cmd_t c);
    list_res_t r;
    int fs;
    logic [SLOT_W-1:0] s, t, p, n;
    bit is_head, is_tail;
    r = '0;
    case (c.command)
      CMD_APPEND, CMD_INSERT: begin
        fs = find_free();
        if (fs < 0) begin
          r.status = ST_FULL;
        end else if (c.command == CMD_INSERT && c.position > m_count) begin
          r.status = ST_RANGE;
        end else begin
          s = SLOT_W'(fs);
          m_used[s] = 1'b1;
          m_data[s] = c.data_word;
          if (c.command == CMD_APPEND || c.position == m_count) begin
            if (m_count == 0) m_head = s;
            else begin
              m_next[m_tail] = s;
              m_prev[s] = m_tail;
            end
            m_tail = s;
            m_next[s] = s;
          end else begin
            t = walk_list(c.position);
            m_next[s] = t;
            if (t == m_head) begin
              m_prev[s] = s;
              m_head = s;
            end else begin
              p = m_prev[t];
              m_prev[s] = p;
              m_next[p] = s;
            end
            m_prev[t] = s;
          end
          m_count++;
          r.slot = s;
          r.slot_valid = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (m_count == 0) r.status = ST_EMPTY;
        else if (c.position >= m_count) r.status = ST_RANGE;
        else begin
          t = walk_list(c.position);
          is_head = (t == m_head);
          is_tail = (t == m_tail);
          p = m_prev[t];
          n = m_next[t];
          if (is_head) m_head = n;
          else m_next[p] = is_tail ? p : n;
          if (is_tail) m_tail = p;
          else m_prev[n] = is_head ? n : p;
          m_used[t] = 1'b0;
          m_count--;
          if (m_count == 0) begin
            m_head = '0;
            m_tail = '0;
          end
          if (!is_tail) begin
            r.slot = n;
            r.slot_valid = 1'b1;
            r.next_data = m_data[n];
          end
        end
      end
      default: ;
    endcase
    r.length = CNT_W'(m_count);
    return r;
  endfunction

  // one transaction on the command channel, then any gap
  task automatic send_cmd(list_cmd_t c);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c.command;
    in_ch.position  <= c.position;
    in_ch.data_word <= c.data_word;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(), apply_list_cmd(c));
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random command; mostly valid positions to reach deep into the list
  function automatic list_cmd_t rand_cmd(int ins_w, int ers_w);
    list_cmd_t c;
    int k;
    k = $urandom_range(99);
    c.data_word = $urandom();
    if (k < 100 - ins_w - ers_w - 3) c.command = CMD_APPEND;
    else if (k < 100 - ers_w - 3) c.command = CMD_INSERT;
    else if (k < 97) c.command = CMD_ERASE;
    else c.command = CMD_NOP;
    if ($urandom_range(19) == 0) c.position = POS_W'($urandom());
    else if ($urandom_range(9) == 0) c.position = POS_W'(m_count);
    else c.position = (m_count == 0) ? '0 : POS_W'($urandom_range(m_count - 1));
    return c;
  endfunction

  // result checking with receiver stalls
  initial begin : receiver
    list_res_t e;
    int mode;
    out_ch.ready <= 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready && rst_n) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction");
          fail_cnt++;
        end else begin
          e = pending_results.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_ch.status); fail_cnt++;
          end
          if (out_ch.slot !== e.slot) begin
            $error("slot exp %0d got %0d", e.slot, out_ch.slot); fail_cnt++;
          end
          if (out_ch.slot_valid !== e.slot_valid) begin
            $error("slot_valid exp %0d got %0d", e.slot_valid, out_ch.slot_valid);
            fail_cnt++;
          end
          if (out_ch.next_data !== e.next_data) begin
            $error("next_data exp %h got %h", e.next_data, out_ch.next_data); fail_cnt++;
          end
          if (out_ch.length !== e.length) begin
            $error("length exp %0d got %0d", e.length, out_ch.length); fail_cnt++;
          end
        end
      end
      if ($urandom_range(63) == 0) mode = $urandom_range(2);
      if (hold_off) out_ch.ready <= 1'b0;
      else case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(3) != 0);
        default: out_ch.ready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin : long_stall
    hold_off = 1'b0;
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    list_cmd_t c;
    row_t row;
    int burst;
    int n_sent;
    bit drained;
    fail_cnt = 0;
    drained = 1'b0;
    m_head = '0; m_tail = '0; m_count = 0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      m_used[i] = 0; m_prev[i] = '0; m_next[i] = '0; m_data[i] = '0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_APPEND;
    in_ch.position = '0;
    in_ch.data_word = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    dir_rows = '{
      '{'{CMD_ERASE,  10'd0,    32'h0},        1, mk_res(ST_EMPTY, 0, 0, 0, 0)},
      '{'{CMD_NOP,    10'd1023, 32'hFFFFFFFF}, 1, mk_res(ST_OK, 0, 0, 0, 0)},
      '{'{CMD_INSERT, 10'd1,    32'h1},        1, mk_res(ST_RANGE, 0, 0, 0, 0)},
      '{'{CMD_INSERT, 10'd0,    32'hFFFFFFFF}, 1, mk_res(ST_OK, 0, 1, 0, 1)},
      '{'{CMD_ERASE,  10'd0,    32'h0},        1, mk_res(ST_OK, 0, 0, 0, 0)},
      '{'{CMD_APPEND, 10'd1023, 32'h00000000}, 1, mk_res(ST_OK, 0, 1, 0, 1)},
      '{'{CMD_APPEND, 10'd0,    32'hA5A5A5A5}, 1, mk_res(ST_OK, 1, 1, 0, 2)},
      '{'{CMD_INSERT, 10'd2,    32'h5A5A5A5A}, 1, mk_res(ST_OK, 2, 1, 0, 3)},
      '{'{CMD_INSERT, 10'd0,    32'h12345678}, 0, '0},
      '{'{CMD_INSERT, 10'd2,    32'h87654321}, 0, '0},
      '{'{CMD_ERASE,  10'd5,    32'h0},        1, mk_res(ST_RANGE, 0, 0, 0, 5)},
      '{'{CMD_ERASE,  10'd1023, 32'h0},        1, mk_res(ST_RANGE, 0, 0, 0, 5)},
      '{'{CMD_ERASE,  10'd4,    32'h0},        0, '0},
      '{'{CMD_ERASE,  10'd0,    32'h0},        0, '0},
      '{'{CMD_ERASE,  10'd1,    32'h0},        0, '0},
      '{'{CMD_INSERT, 10'd1023, 32'h0},        1, mk_res(ST_RANGE, 0, 0, 0, 2)},
      '{'{CMD_ERASE,  10'd0,    32'h0},        0, '0},
      '{'{CMD_ERASE,  10'd0,    32'h0},        0, '0}
    };
    wait (rst_n);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_cmd(row.c);
      if (row.check_row && pending_results[$] != row.r) begin
        $error("directed row %0d: model exp %p table %p", i, pending_results[$], row.r);
        fail_cnt++;
      end
      if ($urandom_range(1)) drop_valid();
    end

    // random traffic in bursts; the middle phase grows the list
    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n_sent < N_RANDOM; b++) begin
        if (n_sent < 150) c = rand_cmd(30, 35);
        else if (n_sent < 300) c = rand_cmd(10, 5);
        else c = rand_cmd(25, 45);
        send_cmd(c);
        n_sent++;
      end
      if (!drained && n_sent >= 200) begin
        // wait until the block has drained
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else if ($urandom_range(2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    // position bounds at the end of the run
    c.command = CMD_INSERT; c.position = 10'd3; c.data_word = 32'hDEADBEEF;
    send_cmd(c);
    c.command = CMD_APPEND;
    send_cmd(c);
    c.command = CMD_ERASE; c.position = 10'd1023;
    send_cmd(c);
    c.command = CMD_INSERT; c.position = 10'd1023;
    send_cmd(c);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[pooled_doubly_linked_list_core] OK");
    end else begin
      $display("[pooled_doubly_linked_list_core] ERROR");
    end
    $finish;
  end

endmodule
